### rtl/cvfd_pkg.sv
// ----------------------------------------------------------------------------
// cvfd_pkg
// Shared constants and types of the curvilinear finite-difference gradient.
// ----------------------------------------------------------------------------
package cvfd_pkg;

  // Register port geometry: two 32-bit registers at byte addresses 0 and 4
  localparam int unsigned ApbDataBits = 32;
  localparam int unsigned ApbAddrBits = 3;
  localparam int unsigned RegIdxBits  = 1;

  // Register indexes
  localparam logic [RegIdxBits-1:0] RegLastRow = 1'b0;
  localparam logic [RegIdxBits-1:0] RegLastCol = 1'b1;

  // Stage enables handed to each product lane
  typedef struct packed {
    logic mul_en;
    logic rnd_en;
  } lane_ctrl_t;

endpackage

### rtl/cvfd_apb_regs.sv
// ----------------------------------------------------------------------------
// cvfd_apb_regs
// Register port holding the last row and last column indexes of the grid.
// ----------------------------------------------------------------------------
module cvfd_apb_regs #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cvfd_pkg::ApbAddrBits-1:0]    paddr,
  input  logic [cvfd_pkg::ApbDataBits-1:0]    pwdata,
  output logic [cvfd_pkg::ApbDataBits-1:0]    prdata,
  output logic                                pready,
  output logic [INDEX_BITS-1:0]               last_row_o,
  output logic [INDEX_BITS-1:0]               last_col_o
);

  localparam int unsigned PadBits = cvfd_pkg::ApbDataBits - INDEX_BITS;

  logic [INDEX_BITS-1:0]             last_row_q, last_row_d;
  logic [INDEX_BITS-1:0]             last_col_q, last_col_d;
  logic [cvfd_pkg::RegIdxBits-1:0]   reg_idx;
  logic                              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[cvfd_pkg::ApbAddrBits-1:2];
  assign wr_en   = psel & penable & pwrite;

  // Decode the write
  always_comb begin
    last_row_d = last_row_q;
    last_col_d = last_col_q;
    if (wr_en) begin
      unique case (reg_idx)
        cvfd_pkg::RegLastRow: last_row_d = pwdata[INDEX_BITS-1:0];
        cvfd_pkg::RegLastCol: last_col_d = pwdata[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_row_q <= INDEX_BITS'(1);
      last_col_q <= INDEX_BITS'(1);
    end else begin
      last_row_q <= last_row_d;
      last_col_q <= last_col_d;
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (reg_idx)
      cvfd_pkg::RegLastRow: prdata = {{PadBits{1'b0}}, last_row_q};
      cvfd_pkg::RegLastCol: prdata = {{PadBits{1'b0}}, last_col_q};
      default:              prdata = '0;
    endcase
  end

  assign last_row_o = last_row_q;
  assign last_col_o = last_col_q;

endmodule

### rtl/cvfd_diff.sv
// ----------------------------------------------------------------------------
// cvfd_diff
// Index-space difference along one grid direction: central, one-sided at
// the edges, or zero for a single-cell direction.
// ----------------------------------------------------------------------------
module cvfd_diff #(
  parameter int unsigned INDEX_BITS = 10,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        [INDEX_BITS-1:0] pos_i,
  input  logic        [INDEX_BITS-1:0] last_i,
  input  logic signed [VALUE_BITS-1:0] center_i,
  input  logic signed [VALUE_BITS-1:0] next_i,
  input  logic signed [VALUE_BITS-1:0] prev_i,
  output logic signed [VALUE_BITS:0]   diff_o
);

  logic signed [VALUE_BITS:0] c_ext, n_ext, p_ext, central;
  logic                       at_first, at_last;

  assign c_ext    = {center_i[VALUE_BITS-1], center_i};
  assign n_ext    = {next_i[VALUE_BITS-1], next_i};
  assign p_ext    = {prev_i[VALUE_BITS-1], prev_i};
  assign central  = n_ext - p_ext;
  assign at_first = (pos_i == '0);
  assign at_last  = (pos_i >= last_i);

  // Pick the stencil; halve the central one with floor rounding
  always_comb begin
    if (at_first && at_last) begin
      diff_o = '0;
    end else if (at_first) begin
      diff_o = n_ext - c_ext;
    end else if (at_last) begin
      diff_o = c_ext - p_ext;
    end else begin
      diff_o = central >>> 1;
    end
  end

endmodule

### rtl/cvfd_lane.sv
// ----------------------------------------------------------------------------
// cvfd_lane
// One coefficient-by-difference product: a multiply stage, then a stage
// that rounds to nearest (ties up) and drops the fraction bits.
// ----------------------------------------------------------------------------
module cvfd_lane #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                      clk_i,
  input  cvfd_pkg::lane_ctrl_t                      ctrl_i,
  input  logic signed [VALUE_BITS-1:0]              coef_i,
  input  logic signed [VALUE_BITS:0]                diff_i,
  output logic signed [2*VALUE_BITS-FRAC_BITS:0]    rnd_o
);

  localparam int unsigned ProdBits = 2 * VALUE_BITS + 1;
  localparam int unsigned RndBits  = ProdBits - FRAC_BITS;
  localparam logic signed [ProdBits-1:0] Half = ProdBits'(1) <<< (FRAC_BITS - 1);

  logic signed [ProdBits-1:0] coef_ext, diff_ext;
  logic signed [ProdBits-1:0] prod_d, prod_q;
  logic signed [ProdBits-1:0] biased;
  logic signed [ProdBits-1:0] shifted;
  logic signed [RndBits-1:0]  rnd_d, rnd_q;

  assign coef_ext = {{(ProdBits-VALUE_BITS){coef_i[VALUE_BITS-1]}}, coef_i};
  assign diff_ext = {{(ProdBits-VALUE_BITS-1){diff_i[VALUE_BITS]}}, diff_i};
  assign prod_d   = coef_ext * diff_ext;

  // Round half up, then drop the fraction
  assign biased   = prod_q + Half;
  assign shifted  = biased >>> FRAC_BITS;
  assign rnd_d    = shifted[RndBits-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.rnd_en) begin
      rnd_q <= rnd_d;
    end
  end

  assign rnd_o = rnd_q;

endmodule

### rtl/curvilinear_fd_gradient.sv
// ----------------------------------------------------------------------------
// curvilinear_fd_gradient
// Gradient of a Q-format field at one cell of a curvilinear grid: index-space
// differences, then a 2x2 inverse-metric transform with rounding and
// saturation.
// ----------------------------------------------------------------------------
//  Channel    Dir   Handshake                 Payload
//  s_axis     in    s_axis_tvalid/tready      row, col, five field values,
//                                             four metric coefficients
//  m_axis     out   m_axis_tvalid/tready      grad_x, grad_y, saturated
//  apb        in    psel/penable/pready       last_row @0x0, last_col @0x4
//
//  One cell per cycle while the output is not stalled; a cell passes the
//  difference, multiply, round and sum-and-saturate stages in that order.
//  Each stage holds its item while the next one is full and stalled, so
//  bubbles close up and backpressure stalls input only when all are full.
//  Reset clears the stage valid bits and sets both index registers to one.
// ----------------------------------------------------------------------------
module curvilinear_fd_gradient #(
  parameter int unsigned INDEX_BITS = 10,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // row, col, q_center, q_row_next, q_row_prev, q_col_next, q_col_prev,
  // coef_chi_x, coef_eta_x, coef_chi_y, coef_eta_y (low bits first)
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((2*INDEX_BITS+9*VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // grad_x, grad_y, saturated (low bits first)
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((2*VALUE_BITS+1+7)/8)*8-1:0] m_axis_tdata,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cvfd_pkg::ApbAddrBits-1:0]  paddr,
  input  logic [cvfd_pkg::ApbDataBits-1:0]  pwdata,
  output logic [cvfd_pkg::ApbDataBits-1:0]  prdata,
  output logic                              pready
);

  localparam int unsigned OutBits = ((2*VALUE_BITS+1+7)/8)*8;
  localparam int unsigned VOff    = 2 * INDEX_BITS;
  localparam int unsigned RndBits = 2 * VALUE_BITS + 1 - FRAC_BITS;
  localparam int unsigned SumBits = RndBits + 1;
  localparam int unsigned TopBits = SumBits - VALUE_BITS + 1;
  localparam logic signed [VALUE_BITS-1:0] ValMax = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] ValMin = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Unpack the input fields
  logic        [INDEX_BITS-1:0] row, col;
  logic signed [VALUE_BITS-1:0] q_center, q_row_next, q_row_prev, q_col_next, q_col_prev;
  logic signed [VALUE_BITS-1:0] coef_chi_x, coef_eta_x, coef_chi_y, coef_eta_y;

  assign row        = s_axis_tdata[INDEX_BITS-1:0];
  assign col        = s_axis_tdata[2*INDEX_BITS-1:INDEX_BITS];
  assign q_center   = s_axis_tdata[VOff+0*VALUE_BITS +: VALUE_BITS];
  assign q_row_next = s_axis_tdata[VOff+1*VALUE_BITS +: VALUE_BITS];
  assign q_row_prev = s_axis_tdata[VOff+2*VALUE_BITS +: VALUE_BITS];
  assign q_col_next = s_axis_tdata[VOff+3*VALUE_BITS +: VALUE_BITS];
  assign q_col_prev = s_axis_tdata[VOff+4*VALUE_BITS +: VALUE_BITS];
  assign coef_chi_x = s_axis_tdata[VOff+5*VALUE_BITS +: VALUE_BITS];
  assign coef_eta_x = s_axis_tdata[VOff+6*VALUE_BITS +: VALUE_BITS];
  assign coef_chi_y = s_axis_tdata[VOff+7*VALUE_BITS +: VALUE_BITS];
  assign coef_eta_y = s_axis_tdata[VOff+8*VALUE_BITS +: VALUE_BITS];

  // Configuration registers
  logic [INDEX_BITS-1:0] last_row, last_col;

  cvfd_apb_regs #(
    .INDEX_BITS (INDEX_BITS)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .last_row_o (last_row),
    .last_col_o (last_col)
  );

  // Stage valid bits and the ready chain, from the output back
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: index-space differences
  logic signed [VALUE_BITS:0]   d_eta_d, d_chi_d, d_eta_q, d_chi_q;
  logic signed [VALUE_BITS-1:0] chi_x_q, eta_x_q, chi_y_q, eta_y_q;

  cvfd_diff #(
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_diff_eta (
    .pos_i    (row),
    .last_i   (last_row),
    .center_i (q_center),
    .next_i   (q_row_next),
    .prev_i   (q_row_prev),
    .diff_o   (d_eta_d)
  );

  cvfd_diff #(
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_diff_chi (
    .pos_i    (col),
    .last_i   (last_col),
    .center_i (q_center),
    .next_i   (q_col_next),
    .prev_i   (q_col_prev),
    .diff_o   (d_chi_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      d_eta_q <= d_eta_d;
      d_chi_q <= d_chi_d;
      chi_x_q <= coef_chi_x;
      eta_x_q <= coef_eta_x;
      chi_y_q <= coef_chi_y;
      eta_y_q <= coef_eta_y;
    end
  end

  // Stages 2 and 3: four product lanes
  cvfd_pkg::lane_ctrl_t lane_ctrl;
  logic signed [RndBits-1:0] r_chi_x, r_eta_x, r_chi_y, r_eta_y;

  assign lane_ctrl.mul_en = rdy2;
  assign lane_ctrl.rnd_en = rdy3;

  cvfd_lane #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_chi_x (
    .clk_i (clk_i), .ctrl_i (lane_ctrl), .coef_i (chi_x_q), .diff_i (d_chi_q),
    .rnd_o (r_chi_x)
  );

  cvfd_lane #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_eta_x (
    .clk_i (clk_i), .ctrl_i (lane_ctrl), .coef_i (eta_x_q), .diff_i (d_eta_q),
    .rnd_o (r_eta_x)
  );

  cvfd_lane #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_chi_y (
    .clk_i (clk_i), .ctrl_i (lane_ctrl), .coef_i (chi_y_q), .diff_i (d_chi_q),
    .rnd_o (r_chi_y)
  );

  cvfd_lane #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_eta_y (
    .clk_i (clk_i), .ctrl_i (lane_ctrl), .coef_i (eta_y_q), .diff_i (d_eta_q),
    .rnd_o (r_eta_y)
  );

  // Stage 4: sum the rounded products and saturate
  logic signed [SumBits-1:0]    sum_x, sum_y;
  logic        [TopBits-1:0]    top_x, top_y;
  logic                         ovf_x, ovf_y;
  logic signed [VALUE_BITS-1:0] grad_x_d, grad_y_d, grad_x_q, grad_y_q;
  logic                         sat_d, sat_q;

  assign sum_x = {r_chi_x[RndBits-1], r_chi_x} + {r_eta_x[RndBits-1], r_eta_x};
  assign sum_y = {r_chi_y[RndBits-1], r_chi_y} + {r_eta_y[RndBits-1], r_eta_y};
  assign top_x = sum_x[SumBits-1:VALUE_BITS-1];
  assign top_y = sum_y[SumBits-1:VALUE_BITS-1];
  assign ovf_x = (top_x != '0) && (top_x != '1);
  assign ovf_y = (top_y != '0) && (top_y != '1);

  always_comb begin
    if (!ovf_x) begin
      grad_x_d = sum_x[VALUE_BITS-1:0];
    end else if (sum_x[SumBits-1]) begin
      grad_x_d = ValMin;
    end else begin
      grad_x_d = ValMax;
    end
    if (!ovf_y) begin
      grad_y_d = sum_y[VALUE_BITS-1:0];
    end else if (sum_y[SumBits-1]) begin
      grad_y_d = ValMin;
    end else begin
      grad_y_d = ValMax;
    end
    sat_d = ovf_x | ovf_y;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      grad_x_q <= grad_x_d;
      grad_y_q <= grad_y_d;
      sat_q    <= sat_d;
    end
  end

  // Pack the result
  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {{(OutBits-2*VALUE_BITS-1){1'b0}}, sat_q, grad_y_q, grad_x_q};

endmodule

### test/tb_curvilinear_fd_gradient.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_curvilinear_fd_gradient
// Streams grid cells through the gradient block and checks every result
// against a bit-exact predictor of the differences, the rounded metric
// products and the saturation. The index limits are set over the register
// port between phases, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_curvilinear_fd_gradient;

  localparam int unsigned IndexBits = 10;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned InBits    = ((2*IndexBits + 9*ValueBits + 7) / 8) * 8;
  localparam int unsigned OutBits   = ((2*ValueBits + 1 + 7) / 8) * 8;
  localparam int unsigned PipeDepth = 4;

  localparam logic [cvfd_pkg::ApbAddrBits-1:0] AddrLastRow = {cvfd_pkg::RegLastRow, 2'b00};
  localparam logic [cvfd_pkg::ApbAddrBits-1:0] AddrLastCol = {cvfd_pkg::RegLastCol, 2'b00};

  // Q16.16 values used by the directed cells
  localparam logic [31:0] QOne    = 32'h0001_0000;
  localparam logic [31:0] QNegOne = 32'hffff_0000;
  localparam logic [31:0] QHalf   = 32'h0000_8000;
  localparam logic [31:0] QMax    = 32'h7fff_ffff;
  localparam logic [31:0] QMin    = 32'h8000_0000;

  localparam logic signed [49:0] GradMax = 50'sh0_7fff_ffff;
  localparam logic signed [49:0] GradMin = -50'sh0_8000_0000;

  // Fields listed from the high bits down, so row sits in the low bits of tdata
  typedef struct packed {
    logic signed [31:0] coef_eta_y;
    logic signed [31:0] coef_chi_y;
    logic signed [31:0] coef_eta_x;
    logic signed [31:0] coef_chi_x;
    logic signed [31:0] q_col_prev;
    logic signed [31:0] q_col_next;
    logic signed [31:0] q_row_prev;
    logic signed [31:0] q_row_next;
    logic signed [31:0] q_center;
    logic [9:0]         col;
    logic [9:0]         row;
  } cell_t;

  typedef struct packed {
    logic               saturated;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_x;
  } grad_t;

  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyCoin,
    ReadyPeriodic,
    ReadyRare
  } ready_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InBits-1:0]  s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OutBits-1:0] m_axis_tdata;

  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [cvfd_pkg::ApbAddrBits-1:0] paddr = '0;
  logic [cvfd_pkg::ApbDataBits-1:0] pwdata = '0;
  logic [cvfd_pkg::ApbDataBits-1:0] prdata;
  logic                             pready;

  cell_t pending_cells[$];
  grad_t expected_grads[$];

  // Register copies, followed from the bus
  logic [9:0] limit_row = 10'd1;
  logic [9:0] limit_col = 10'd1;

  int unsigned queued_count = 0;
  int unsigned checked_count = 0;
  int unsigned mismatch_count = 0;
  logic        in_fire_q = 1'b0;

  // Sender burst state
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  // Receiver stall state
  ready_mode_e ready_mode = ReadyAlways;
  int unsigned ready_left = 0;
  int unsigned ready_period = 2;
  int unsigned ready_tick = 0;

  curvilinear_fd_gradient #(
    .INDEX_BITS(IndexBits),
    .VALUE_BITS(ValueBits),
    .FRAC_BITS (FracBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Index-space difference: zero for a single cell, one-sided at the edges, halved central inside
  function automatic logic signed [32:0] index_difference(
      logic [9:0] pos, logic [9:0] last, logic signed [31:0] center,
      logic signed [31:0] next_q, logic signed [31:0] prev_q);
    logic signed [32:0] c;
    logic signed [32:0] n;
    logic signed [32:0] p;
    logic signed [32:0] d;
    c = 33'(center);
    n = 33'(next_q);
    p = 33'(prev_q);
    if (pos == 10'd0 && last == 10'd0) begin
      d = '0;
    end else if (pos == 10'd0) begin
      d = n - c;
    end else if (pos >= last) begin
      d = c - p;
    end else begin
      d = (n - p) >>> 1;
    end
    return d;
  endfunction

  // Exact product, rounded to nearest with ties up, fraction bits dropped
  function automatic logic signed [49:0] rounded_product(logic signed [31:0] coef,
                                                         logic signed [32:0] diff);
    logic signed [65:0] p;
    p = 66'(coef) * 66'(diff);
    p = p + (66'sd1 <<< (FracBits - 1));
    return 50'(p >>> FracBits);
  endfunction

  // Clip to Q16.16; the top bit tells whether clipping happened
  function automatic logic [32:0] saturate_sum(logic signed [49:0] s);
    if (s > GradMax) return {1'b1, QMax};
    if (s < GradMin) return {1'b1, QMin};
    return {1'b0, s[31:0]};
  endfunction

  function automatic grad_t predict_gradient(cell_t c, logic [9:0] lr, logic [9:0] lc);
    logic signed [32:0] d_eta;
    logic signed [32:0] d_chi;
    logic [32:0]        sx;
    logic [32:0]        sy;
    grad_t              g;
    d_eta = index_difference(c.row, lr, c.q_center, c.q_row_next, c.q_row_prev);
    d_chi = index_difference(c.col, lc, c.q_center, c.q_col_next, c.q_col_prev);
    sx = saturate_sum(rounded_product(c.coef_chi_x, d_chi) +
                      rounded_product(c.coef_eta_x, d_eta));
    sy = saturate_sum(rounded_product(c.coef_chi_y, d_chi) +
                      rounded_product(c.coef_eta_y, d_eta));
    g.grad_x    = sx[31:0];
    g.grad_y    = sy[31:0];
    g.saturated = sx[32] | sy[32];
    return g;
  endfunction

  function automatic cell_t make_cell(logic [9:0] row, logic [9:0] col, logic [31:0] qc,
      logic [31:0] rn, logic [31:0] rp, logic [31:0] cn, logic [31:0] cp,
      logic [31:0] cx, logic [31:0] ex, logic [31:0] cy, logic [31:0] ey);
    cell_t c;
    c.row        = row;
    c.col        = col;
    c.q_center   = qc;
    c.q_row_next = rn;
    c.q_row_prev = rp;
    c.q_col_next = cn;
    c.q_col_prev = cp;
    c.coef_chi_x = cx;
    c.coef_eta_x = ex;
    c.coef_chi_y = cy;
    c.coef_eta_y = ey;
    return c;
  endfunction

  // Favor the edges, the last index and the region beyond it
  function automatic logic [9:0] pick_index(logic [9:0] last);
    logic [9:0] v;
    case ($urandom_range(0, 7))
      0: v = 10'd0;
      1: v = last;
      2: v = (last == 10'd0) ? 10'd0 : last - 10'd1;
      3: v = (last == 10'h3ff) ? last : 10'($urandom_range(last + 1, 1023));
      4: v = 10'($urandom_range(0, 1023));
      default: v = 10'($urandom_range(0, last));
    endcase
    return v;
  endfunction

  // Mix extremes, small values near zero and full-range values
  function automatic logic [31:0] pick_value();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 11))
      0: r = QMax;
      1: r = QMin;
      2: r = '0;
      3: r = 32'hffff_ffff;
      4, 5, 6: r = {{12{r[19]}}, r[19:0]};
      default: r = r;
    endcase
    return r;
  endfunction

  function automatic cell_t random_cell(logic [9:0] lr, logic [9:0] lc);
    return make_cell(pick_index(lr), pick_index(lc), pick_value(), pick_value(),
                     pick_value(), pick_value(), pick_value(), pick_value(),
                     pick_value(), pick_value(), pick_value());
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic queue_cell(cell_t c);
    pending_cells.push_back(c);
    queued_count++;
  endtask

  // Hold until every queued cell has come back, then let the pipe settle
  task automatic wait_drain();
    while (checked_count != queued_count) @(negedge clk_i);
    repeat (PipeDepth + 4) @(negedge clk_i);
  endtask

  // One register transfer: setup cycle, then access cycle until pready
  task automatic apb_transfer(logic wr, logic [cvfd_pkg::ApbAddrBits-1:0] addr,
                              logic [cvfd_pkg::ApbDataBits-1:0] wdata,
                              output logic [cvfd_pkg::ApbDataBits-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(logic [cvfd_pkg::ApbAddrBits-1:0] addr, logic [9:0] want);
    logic [cvfd_pkg::ApbDataBits-1:0] got;
    apb_transfer(1'b0, addr, '0, got);
    if (got != {{(cvfd_pkg::ApbDataBits-10){1'b0}}, want})
      report_mismatch($sformatf("register @%0h read %h, want %h", addr, got, want));
  endtask

  task automatic set_limits(logic [9:0] lr, logic [9:0] lc);
    logic [cvfd_pkg::ApbDataBits-1:0] unused;
    wait_drain();
    apb_transfer(1'b1, AddrLastRow, {{(cvfd_pkg::ApbDataBits-10){1'b0}}, lr}, unused);
    apb_transfer(1'b1, AddrLastCol, {{(cvfd_pkg::ApbDataBits-10){1'b0}}, lc}, unused);
    check_register(AddrLastRow, lr);
    check_register(AddrLastCol, lc);
  endtask

  task automatic run_random(logic [9:0] lr, logic [9:0] lc, int unsigned count);
    set_limits(lr, lc);
    repeat (count) queue_cell(random_cell(lr, lc));
    wait_drain();
  endtask

  // Drive cells in bursts; hold the current cell until its transfer
  always @(negedge clk_i) begin
    cell_t next_cell;
    if (rst_ni && (in_fire_q || !s_axis_tvalid)) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cells.size() != 0) begin
        next_cell = pending_cells.pop_front();
        s_axis_tdata  <= {{(InBits-$bits(cell_t)){1'b0}}, next_cell};
        s_axis_tvalid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side on a changing pattern
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode   = ready_mode_e'($urandom_range(0, 3));
      ready_left   = $urandom_range(20, 120);
      ready_period = $urandom_range(2, 9);
    end else begin
      ready_left--;
    end
    ready_tick++;
    case (ready_mode)
      ReadyAlways:   m_axis_tready <= 1'b1;
      ReadyCoin:     m_axis_tready <= 1'($urandom_range(0, 1));
      ReadyPeriodic: m_axis_tready <= (ready_tick % ready_period) != 0;
      default:       m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Predict on each input transfer, follow register writes, check results
  always @(posedge clk_i) begin
    cell_t seen_cell;
    grad_t got;
    grad_t want;
    if (rst_ni) begin
      in_fire_q <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        seen_cell = s_axis_tdata[$bits(cell_t)-1:0];
        expected_grads.push_back(predict_gradient(seen_cell, limit_row, limit_col));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          cvfd_pkg::RegLastRow: limit_row <= pwdata[9:0];
          cvfd_pkg::RegLastCol: limit_col <= pwdata[9:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(grad_t)-1:0];
        checked_count++;
        if (expected_grads.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %h", got));
        end else begin
          want = expected_grads.pop_front();
          if (got.grad_x !== want.grad_x || got.grad_y !== want.grad_y ||
              got.saturated !== want.saturated)
            report_mismatch($sformatf("gx %h/%h gy %h/%h sat %b/%b (got/want)",
                                      got.grad_x, want.grad_x, got.grad_y, want.grad_y,
                                      got.saturated, want.saturated));
        end
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits are one in both directions
    check_register(AddrLastRow, 10'd1);
    check_register(AddrLastCol, 10'd1);

    // Forward on index zero, backward on the last index and beyond it
    queue_cell(make_cell(10'd0, 10'd0, '0, QOne, $urandom(), 32'h0002_0000, $urandom(),
                         QOne, QOne, QOne, QNegOne));
    queue_cell(make_cell(10'd1, 10'd1, QOne, $urandom(), '0, $urandom(), 32'h0003_0000,
                         QOne, QNegOne, QHalf, QOne));
    queue_cell(make_cell(10'd2, 10'd700, pick_value(), $urandom(), pick_value(),
                         $urandom(), pick_value(), pick_value(), pick_value(),
                         pick_value(), pick_value()));
    queue_cell(make_cell(10'h3ff, 10'h3ff, pick_value(), $urandom(), pick_value(),
                         $urandom(), pick_value(), QMin, QMax, QMax, QMin));
    // Largest differences against the largest coefficients clip both ways
    queue_cell(make_cell(10'd0, 10'd0, QMin, QMax, $urandom(), QMax, $urandom(),
                         QMax, QMax, QMax, QMax));
    queue_cell(make_cell(10'd1, 10'd1, QMin, $urandom(), QMax, $urandom(), QMax,
                         QMax, QMax, QMin, QMin));
    // Rounding ties at plus and minus one half of an lsb
    queue_cell(make_cell(10'd0, 10'd0, '0, 32'd1, $urandom(), '0, $urandom(),
                         '0, QHalf, '0, '0));
    queue_cell(make_cell(10'd0, 10'd0, 32'd1, '0, $urandom(), '0, $urandom(),
                         '0, QHalf, QHalf, '0));
    // Only the y gradient clips
    queue_cell(make_cell(10'd0, 10'd0, '0, '0, $urandom(), QMax, $urandom(),
                         '0, '0, QMax, '0));
    // Zero coefficients cancel any difference
    queue_cell(make_cell(10'd0, 10'd1, QMax, QMin, QMax, QMin, QMin, '0, '0, '0, '0));

    // Single cell in both directions: differences vanish at index zero
    set_limits(10'd0, 10'd0);
    queue_cell(make_cell(10'd0, 10'd0, QMax, QMin, QMin, QMin, QMin,
                         QMax, QMax, QMax, QMax));
    queue_cell(make_cell(10'd3, 10'd0, QOne, $urandom(), QNegOne, $urandom(), $urandom(),
                         QOne, QOne, QOne, QOne));
    queue_cell(make_cell(10'd0, 10'd9, QNegOne, $urandom(), $urandom(), $urandom(), QOne,
                         QOne, QOne, QNegOne, QHalf));
    repeat (20) queue_cell(random_cell(10'd0, 10'd0));
    wait_drain();

    // Central differences with odd spans and floor halving
    set_limits(10'h3ff, 10'h3ff);
    queue_cell(make_cell(10'd5, 10'd7, '0, 32'd3, '0, '0, 32'd3, QOne, QOne, QOne, QOne));
    queue_cell(make_cell(10'd500, 10'd500, $urandom(), QMax, QMin, QMin, QMax,
                         QOne, QOne, QOne, QNegOne));
    queue_cell(make_cell(10'd1022, 10'd1, pick_value(), pick_value(), pick_value(),
                         pick_value(), pick_value(), QOne, QHalf, QNegOne, QOne));
    queue_cell(make_cell(10'h3ff, 10'h3ff, pick_value(), $urandom(), pick_value(),
                         $urandom(), pick_value(), QMax, QMin, QMin, QMax));
    queue_cell(make_cell(10'd1, 10'd1022, pick_value(), pick_value(), pick_value(),
                         pick_value(), pick_value(), pick_value(), pick_value(),
                         pick_value(), pick_value()));
    repeat (220) queue_cell(random_cell(10'h3ff, 10'h3ff));
    wait_drain();

    // Sweep the limits through narrow, skewed and random grids
    run_random(10'd1, 10'h3ff, 180);
    run_random(10'h3ff, 10'd1, 180);
    run_random(10'd2, 10'd3, 180);
    run_random(10'($urandom_range(1, 8)), 10'($urandom_range(1, 8)), 180);
    run_random(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)), 180);
    run_random(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)), 180);
    run_random(10'd1, 10'd1, 130);

    wait_drain();
    if (mismatch_count == 0) begin
      $display("curvilinear_fd_gradient verification clean");
    end else begin
      $display("curvilinear_fd_gradient verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("curvilinear_fd_gradient verification failed");
    $finish;
  end

endmodule
